### rtl/core/hwe_pkg.sv
// ----------------------------------------------------------------------------
// hwe_pkg
// Shared types and fixed constants of the Hardy-Weinberg exact test block.
// ----------------------------------------------------------------------------
`default_nettype none

package hwe_pkg;

  // Genotype count width and fixed-point formats
  localparam int unsigned CNT_W     = 13;
  localparam int unsigned FRAC_W    = 32;
  localparam int unsigned ENTRY_W   = 48;
  localparam int unsigned THR_SHIFT = 27;

  localparam logic [FRAC_W-1:0]  Q31_ONE   = 32'h8000_0000;
  localparam logic [ENTRY_W-1:0] ENTRY_ONE = 48'h8000_0000_0000;
  localparam logic [ENTRY_W-1:0] ENTRY_MAX = 48'hFFFF_FFFF_FFFF;

  // Shared arithmetic unit operations
  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic    start;
    alu_op_e op;
  } alu_ctrl_t;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CHECK,
    ST_OBS,
    ST_EXP_A,
    ST_EXP_B,
    ST_EXP_DIV,
    ST_MID_MUL,
    ST_MID_DIV,
    ST_MID_FIX,
    ST_UP_CHK,
    ST_UP_RC,
    ST_UP_DEN,
    ST_UP_MUL,
    ST_UP_DIV,
    ST_DN_CHK,
    ST_DN_NUM,
    ST_DN_DEN,
    ST_DN_MUL,
    ST_DN_DIV,
    ST_OBS_RD,
    ST_OBS_WAIT,
    ST_SW_RD,
    ST_SW_ACC,
    ST_P_PREP,
    ST_P_DIV,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

### rtl/core/hwe_ram.sv
// ----------------------------------------------------------------------------
// hwe_ram
// Generic single-port RAM, one write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hwe_ram #(
  parameter int unsigned  WIDTH = 48,
  parameter int unsigned  DEPTH = 2049,
  localparam int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### rtl/core/hwe_alu.sv
// ----------------------------------------------------------------------------
// hwe_alu
// Shared iterative unit: shift-add multiply (one multiplier bit per cycle)
// and restoring divide (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module hwe_alu #(
  parameter int unsigned DW = 92,
  parameter int unsigned PW = 30
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hwe_pkg::alu_ctrl_t ctrl_i,
  input  logic [DW-1:0]     a_i,
  input  logic [DW-1:0]     b_i,
  output logic              done_o,
  output logic [DW-1:0]     res_o
);

  import hwe_pkg::*;

  localparam int unsigned CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  alu_op_e       op_q;
  logic [DW-1:0] acc_q;   // product or remainder
  logic [DW-1:0] opa_q;   // multiplicand or dividend/quotient
  logic [DW-1:0] opb_q;   // multiplier or divisor

  logic [DW:0]   rem_s;
  logic          ge;
  logic [DW:0]   rem_diff;
  logic [DW-1:0] mul_next;

  // One step of each operation
  always_comb begin
    rem_s    = {acc_q, opa_q[DW-1]};
    ge       = rem_s >= {1'b0, opb_q};
    rem_diff = rem_s - {1'b0, opb_q};
    mul_next = {acc_q[DW-2:0], 1'b0} + (opb_q[PW-1] ? opa_q : '0);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= ALU_MUL;
    end else begin
      done_q <= 1'b0;
      if (ctrl_i.start) begin
        busy_q <= 1'b1;
        op_q   <= ctrl_i.op;
        cnt_q  <= (ctrl_i.op == ALU_MUL) ? CW'(PW) : CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) begin
      acc_q <= '0;
      opa_q <= a_i;
      opb_q <= (ctrl_i.op == ALU_MUL) ? {b_i[PW-1:0], {(DW-PW){1'b0}}} >> (DW - PW)
                                      : b_i;
    end else if (busy_q) begin
      if (op_q == ALU_MUL) begin
        acc_q <= mul_next;
        opb_q <= {opb_q[DW-2:0], 1'b0};
      end else begin
        acc_q <= ge ? rem_diff[DW-1:0] : rem_s[DW-1:0];
        opa_q <= {opa_q[DW-2:0], ge};
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = (op_q == ALU_MUL) ? acc_q : opa_q;

endmodule

`default_nettype wire

### rtl/core/hardy_weinberg_exact_test.sv
// ----------------------------------------------------------------------------
// hardy_weinberg_exact_test
// Exact Hardy-Weinberg test for one biallelic variant: het fraction, 2pq and
// exact p-value (optional mid-p), all unsigned Q1.31.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o   | hom_ref, het, hom_alt counts
//  out     | output    | out_valid_o / out_stall_i | fractions, p-value, flags
//  cfg     | input     | cfg_valid_i / cfg_ready_o | midp_enable
//
//  One item at a time through a shared multiply/divide unit (one bit a cycle).
//  Work per item: the fractions and mode, then each probability table entry in
//  turn, then a summing sweep over the entries (DW=92, PW=30 at the default
//  size; up to MAX_SAMPLES/2+1 entries).
//  Zero or oversized totals skip the table and go straight to the result.
//  Reset clears control only; the table needs no clearing.
//  A result waiting on out_stall_i does not hold up the next item's work.
// ----------------------------------------------------------------------------
`default_nettype none

module hardy_weinberg_exact_test #(
  parameter int unsigned MAX_SAMPLES = 4096
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // config
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_midp_enable_i,
  // input items
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [hwe_pkg::CNT_W-1:0]   hom_ref_count_i,
  input  logic [hwe_pkg::CNT_W-1:0]   het_count_i,
  input  logic [hwe_pkg::CNT_W-1:0]   hom_alt_count_i,
  // results
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [hwe_pkg::FRAC_W-1:0]  observed_het_frac_o,
  output logic [hwe_pkg::FRAC_W-1:0]  expected_het_frac_o,
  output logic [hwe_pkg::FRAC_W-1:0]  p_value_o,
  output logic                        stats_valid_o,
  output logic                        count_overflow_o
);

  import hwe_pkg::*;

  localparam int unsigned DEPTH = MAX_SAMPLES / 2 + 1;
  localparam int unsigned TW    = $clog2(DEPTH);
  localparam int unsigned NW    = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned KW    = NW + 1;
  localparam int unsigned PW    = 2 * NW + 4;
  localparam int unsigned SW    = ENTRY_W + TW;
  localparam int unsigned DW_A  = ENTRY_W + PW;
  localparam int unsigned DW_B  = SW + FRAC_W;
  localparam int unsigned DW    = (DW_A > DW_B) ? DW_A : DW_B;
  localparam int unsigned TOT_W = CNT_W + 2;
  localparam int unsigned CMP_W = ((TOT_W > NW) ? TOT_W : NW) + 2;

  state_e st_q, st_d;

  logic               issued_q;
  logic               midp_q;
  logic [CNT_W-1:0]   h1_q, ht_q, h2_q;
  logic [FRAC_W-1:0]  obs_frac_q, exp_frac_q, p_q;
  logic               sv_q, ovf_q;
  logic [DW-1:0]      tmp_q, den_q;
  logic [KW-1:0]      mid_q, k_q, r_q, c_q;
  logic [ENTRY_W-1:0] prev_q, obs_q;
  logic [SW-1:0]      sum_q, sel_q;
  logic [TW-1:0]      sw_idx_q;

  logic               out_valid_q;
  logic [FRAC_W-1:0]  out_obs_q, out_exp_q, out_p_q;
  logic               out_sv_q, out_ovf_q;

  // Shared unit and table signals
  alu_ctrl_t          alu_ctrl;
  logic [DW-1:0]      alu_a, alu_b, alu_res;
  logic               alu_done;
  logic               alu_state;
  logic               ram_we;
  logic [TW-1:0]      ram_addr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  // Derived values
  logic [TOT_W-1:0]   tot;
  logic [DW-1:0]      n_dw;
  logic [CNT_W-1:0]   homr, homc;
  logic [CNT_W+1:0]   rare_w, common_w, ea, eb;
  logic [KW-1:0]      rare, common;
  logic [KW:0]        mid_adj;
  logic               mid_bad;
  logic               up_more;
  logic [ENTRY_W-1:0] v_sat;
  logic [ENTRY_W:0]   thr;
  logic [DW-1:0]      sel_sh, mid_sub;
  logic               p_neg;
  logic [DW-1:0]      q_half;
  logic               load_out;

  always_comb begin
    tot      = TOT_W'(h1_q) + TOT_W'(ht_q) + TOT_W'(h2_q);
    n_dw     = DW'(tot);
    homr     = (h1_q < h2_q) ? h1_q : h2_q;
    homc     = (h1_q < h2_q) ? h2_q : h1_q;
    rare_w   = {1'b0, homr, 1'b0} + (CNT_W+2)'(ht_q);
    common_w = {1'b0, homc, 1'b0} + (CNT_W+2)'(ht_q);
    ea       = {1'b0, h1_q, 1'b0} + (CNT_W+2)'(ht_q);
    eb       = {1'b0, h2_q, 1'b0} + (CNT_W+2)'(ht_q);
    rare     = KW'(rare_w);
    common   = KW'(common_w);
    mid_adj  = {1'b0, mid_q} + (KW+1)'(mid_q[0] ^ rare[0]);
    mid_bad  = (mid_adj > {1'b0, rare}) ||
               ({1'b0, rare} >= (KW+1)'(2 * DEPTH));
    up_more  = ({1'b0, k_q} + (KW+1)'(2)) <= {1'b0, rare};
    v_sat    = (alu_res > DW'(ENTRY_MAX)) ? ENTRY_MAX : alu_res[ENTRY_W-1:0];
    thr      = {1'b0, obs_q} + (ENTRY_W+1)'(obs_q >> THR_SHIFT);
    sel_sh   = DW'(sel_q) << FRAC_W;
    mid_sub  = midp_q ? (DW'(obs_q) << (FRAC_W - 1)) : '0;
    p_neg    = sel_sh < mid_sub;
    q_half   = alu_res >> 1;
  end

  assign load_out = (st_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE:     if (in_valid_i) st_d = ST_CHECK;
      ST_CHECK: begin
        if (tot == '0 || CMP_W'(tot) > CMP_W'(MAX_SAMPLES)) st_d = ST_DONE;
        else st_d = ST_OBS;
      end
      ST_OBS:      if (alu_done) st_d = ST_EXP_A;
      ST_EXP_A:    if (alu_done) st_d = ST_EXP_B;
      ST_EXP_B:    if (alu_done) st_d = ST_EXP_DIV;
      ST_EXP_DIV:  if (alu_done) st_d = ST_MID_MUL;
      ST_MID_MUL:  if (alu_done) st_d = ST_MID_DIV;
      ST_MID_DIV:  if (alu_done) st_d = ST_MID_FIX;
      ST_MID_FIX:  st_d = mid_bad ? ST_DONE : ST_UP_CHK;
      ST_UP_CHK:   st_d = up_more ? ST_UP_RC : ST_DN_CHK;
      ST_UP_RC:    if (alu_done) st_d = ST_UP_DEN;
      ST_UP_DEN:   if (alu_done) st_d = ST_UP_MUL;
      ST_UP_MUL:   if (alu_done) st_d = ST_UP_DIV;
      ST_UP_DIV:   if (alu_done) st_d = ST_UP_CHK;
      ST_DN_CHK:   st_d = (k_q >= KW'(2)) ? ST_DN_NUM : ST_OBS_RD;
      ST_DN_NUM:   if (alu_done) st_d = ST_DN_DEN;
      ST_DN_DEN:   if (alu_done) st_d = ST_DN_MUL;
      ST_DN_MUL:   if (alu_done) st_d = ST_DN_DIV;
      ST_DN_DIV:   if (alu_done) st_d = ST_DN_CHK;
      ST_OBS_RD:   st_d = ST_OBS_WAIT;
      ST_OBS_WAIT: st_d = ST_SW_RD;
      ST_SW_RD:    st_d = ST_SW_ACC;
      ST_SW_ACC:   st_d = (sw_idx_q == TW'(rare >> 1)) ? ST_P_PREP : ST_SW_RD;
      ST_P_PREP:   st_d = p_neg ? ST_DONE : ST_P_DIV;
      ST_P_DIV:    if (alu_done) st_d = ST_DONE;
      ST_DONE:     if (load_out) st_d = ST_IDLE;
      default:     st_d = ST_IDLE;
    endcase
  end

  // Shared unit operands and table access
  always_comb begin
    alu_state = 1'b1;
    alu_ctrl  = '{start: 1'b0, op: ALU_MUL};
    alu_a     = '0;
    alu_b     = '0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = v_sat;
    case (st_q)
      ST_OBS: begin
        alu_ctrl.op = ALU_DIV;
        alu_a = DW'(ht_q) << (FRAC_W - 1);
        alu_b = n_dw;
      end
      ST_EXP_A: begin
        alu_a = DW'(ea);
        alu_b = DW'(eb);
      end
      ST_EXP_B: begin
        alu_a = n_dw;
        alu_b = n_dw;
      end
      ST_EXP_DIV: begin
        alu_ctrl.op = ALU_DIV;
        alu_a = tmp_q << (FRAC_W - 2);
        alu_b = den_q;
      end
      ST_MID_MUL: begin
        alu_a = DW'(rare);
        alu_b = DW'(common);
      end
      ST_MID_DIV: begin
        alu_ctrl.op = ALU_DIV;
        alu_a = tmp_q;
        alu_b = n_dw << 1;
      end
      ST_UP_RC: begin
        alu_a = DW'(r_q);
        alu_b = DW'(c_q);
      end
      ST_UP_DEN: begin
        alu_a = DW'(k_q) + DW'(1);
        alu_b = DW'(k_q) + DW'(2);
      end
      ST_UP_MUL, ST_DN_MUL: begin
        alu_a = DW'(prev_q);
        alu_b = tmp_q;
      end
      ST_UP_DIV: begin
        alu_ctrl.op = ALU_DIV;
        alu_a  = tmp_q;
        alu_b  = den_q;
        ram_we = alu_done;
        ram_addr = TW'((k_q + KW'(2)) >> 1);
      end
      ST_DN_NUM: begin
        alu_a = DW'(k_q);
        alu_b = DW'(k_q) - DW'(1);
      end
      ST_DN_DEN: begin
        alu_a = DW'(r_q) + DW'(1);
        alu_b = DW'(c_q) + DW'(1);
      end
      ST_DN_DIV: begin
        alu_ctrl.op = ALU_DIV;
        alu_a  = tmp_q;
        alu_b  = den_q;
        ram_we = alu_done;
        ram_addr = TW'((k_q - KW'(2)) >> 1);
      end
      ST_P_DIV: begin
        alu_ctrl.op = ALU_DIV;
        alu_a = tmp_q;
        alu_b = DW'(sum_q);
      end
      ST_MID_FIX: begin
        alu_state = 1'b0;
        ram_we    = !mid_bad;
        ram_addr  = TW'(mid_adj >> 1);
        ram_wdata = ENTRY_ONE;
      end
      ST_OBS_RD: begin
        alu_state = 1'b0;
        ram_addr  = TW'(ht_q >> 1);
      end
      ST_SW_RD: begin
        alu_state = 1'b0;
        ram_addr  = sw_idx_q;
      end
      default: alu_state = 1'b0;
    endcase
    alu_ctrl.start = alu_state && !issued_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      issued_q    <= 1'b0;
      midp_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (alu_ctrl.start) issued_q <= 1'b1;
      else if (alu_done) issued_q <= 1'b0;
      if (cfg_valid_i) midp_q <= cfg_midp_enable_i;
      if (load_out) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          h1_q <= hom_ref_count_i;
          ht_q <= het_count_i;
          h2_q <= hom_alt_count_i;
        end
      end
      ST_CHECK: begin
        obs_frac_q <= '0;
        exp_frac_q <= '0;
        if (tot == '0) begin
          p_q <= Q31_ONE; sv_q <= 1'b0; ovf_q <= 1'b0;
        end else if (CMP_W'(tot) > CMP_W'(MAX_SAMPLES)) begin
          p_q <= '0; sv_q <= 1'b0; ovf_q <= 1'b1;
        end else begin
          sv_q <= 1'b1; ovf_q <= 1'b0;
        end
      end
      ST_OBS:     if (alu_done) obs_frac_q <= alu_res[FRAC_W-1:0];
      ST_EXP_A:   if (alu_done) tmp_q <= alu_res;
      ST_EXP_B:   if (alu_done) den_q <= alu_res;
      ST_EXP_DIV: if (alu_done) exp_frac_q <= alu_res[FRAC_W-1:0];
      ST_MID_MUL: if (alu_done) tmp_q <= alu_res;
      ST_MID_DIV: if (alu_done) mid_q <= KW'(alu_res);
      ST_MID_FIX: begin
        if (mid_bad) begin
          p_q <= Q31_ONE;
        end else begin
          mid_q  <= KW'(mid_adj);
          k_q    <= KW'(mid_adj);
          r_q    <= KW'(({1'b0, rare} - mid_adj) >> 1);
          c_q    <= KW'(({1'b0, common} - mid_adj) >> 1);
          prev_q <= ENTRY_ONE;
          sum_q  <= SW'(ENTRY_ONE);
        end
      end
      ST_UP_CHK: begin
        // up side done: restart from the mode for the down side
        if (!up_more) begin
          k_q    <= mid_q;
          r_q    <= (rare - mid_q) >> 1;
          c_q    <= (common - mid_q) >> 1;
          prev_q <= ENTRY_ONE;
        end
      end
      ST_UP_RC:  if (alu_done) tmp_q <= alu_res << 2;
      ST_UP_DEN: if (alu_done) den_q <= alu_res;
      ST_UP_MUL, ST_DN_MUL: if (alu_done) tmp_q <= alu_res;
      ST_UP_DIV: begin
        if (alu_done) begin
          prev_q <= v_sat;
          sum_q  <= sum_q + SW'(v_sat);
          k_q    <= k_q + KW'(2);
          r_q    <= r_q - KW'(1);
          c_q    <= c_q - KW'(1);
        end
      end
      ST_DN_NUM: if (alu_done) tmp_q <= alu_res;
      ST_DN_DEN: if (alu_done) den_q <= alu_res << 2;
      ST_DN_DIV: begin
        if (alu_done) begin
          prev_q <= v_sat;
          sum_q  <= sum_q + SW'(v_sat);
          k_q    <= k_q - KW'(2);
          r_q    <= r_q + KW'(1);
          c_q    <= c_q + KW'(1);
        end
      end
      ST_OBS_WAIT: begin
        obs_q    <= ram_rdata;
        sel_q    <= '0;
        sw_idx_q <= '0;
      end
      ST_SW_ACC: begin
        if ({1'b0, ram_rdata} <= thr) sel_q <= sel_q + SW'(ram_rdata);
        sw_idx_q <= sw_idx_q + TW'(1);
      end
      ST_P_PREP: begin
        if (p_neg) p_q <= '0;
        else tmp_q <= sel_sh - mid_sub;
      end
      ST_P_DIV: begin
        if (alu_done) begin
          p_q <= (q_half > DW'(Q31_ONE)) ? Q31_ONE : q_half[FRAC_W-1:0];
        end
      end
      default: ;
    endcase

    // Output register
    if (load_out) begin
      out_obs_q <= obs_frac_q;
      out_exp_q <= exp_frac_q;
      out_p_q   <= p_q;
      out_sv_q  <= sv_q;
      out_ovf_q <= ovf_q;
    end
  end

  hwe_alu #(
    .DW (DW),
    .PW (PW)
  ) u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (alu_ctrl),
    .a_i    (alu_a),
    .b_i    (alu_b),
    .done_o (alu_done),
    .res_o  (alu_res)
  );

  hwe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign cfg_ready_o         = 1'b1;
  assign in_stall_o          = (st_q != ST_IDLE);
  assign out_valid_o         = out_valid_q;
  assign observed_het_frac_o = out_obs_q;
  assign expected_het_frac_o = out_exp_q;
  assign p_value_o           = out_p_q;
  assign stats_valid_o       = out_sv_q;
  assign count_overflow_o    = out_ovf_q;

  // Checks
  a_p_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> p_value_o <= Q31_ONE)
    else $error("p-value above one");

  a_ovf_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && count_overflow_o) |-> (!stats_valid_o && p_value_o == '0))
    else $error("overflow result carries statistics");

  a_alu_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alu_done |-> issued_q)
    else $error("arithmetic unit finished without a request");

  a_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (st_q == ST_CHECK))
    else $error("accepted item not taken up");

endmodule

`default_nettype wire
